// File: design/eeic_pkg.sv
`timescale 1ns / 1ps

package eeic_pkg;

    // Line and port geometry
    localparam int LINE_COUNT      = 16;
    localparam int PORT_COUNT      = 5;
    localparam int PORT_WIDTH      = 16;
    localparam int PORT_E_WIDTH    = 5;
    localparam int ROUTE_REGS      = 4;
    localparam int LINES_PER_ROUTE = 4;
    localparam int NIBBLE_WIDTH    = 4;
    localparam int CODE_WIDTH      = 3;
    localparam int REG_WIDTH       = 16;
    localparam int REG_INDEX_WIDTH = 3;
    localparam int MODE_WIDTH      = 2;
    localparam int IRQ_WIDTH       = 7;

    // Configuration register indexes
    localparam logic [REG_INDEX_WIDTH-1:0] REG_RISING_ENABLE  = 3'd0;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_FALLING_ENABLE = 3'd1;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_IRQ_UNMASK     = 3'd2;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_ROUTE_0_3      = 3'd3;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_ROUTE_4_7      = 3'd4;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_ROUTE_8_11     = 3'd5;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_ROUTE_12_15    = 3'd6;

    // Item modes
    localparam logic [MODE_WIDTH-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_CLEAR  = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_READ   = 2'd2;

    typedef logic [LINE_COUNT-1:0] line_vec_t;
    typedef logic [PORT_WIDTH-1:0] port_vec_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        line_vec_t                                rising_enable;
        line_vec_t                                falling_enable;
        line_vec_t                                irq_unmask;
        logic [ROUTE_REGS-1:0][REG_WIDTH-1:0]     route;
    } cfg_t;

    // One registered input transaction
    typedef struct packed {
        logic [MODE_WIDTH-1:0]                    mode;
        line_vec_t                                clear_bits;
        logic [PORT_COUNT-1:0][PORT_WIDTH-1:0]    ports;
    } item_t;

endpackage

// File: design/eeic_cfg.sv
`timescale 1ns / 1ps

module eeic_cfg
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [eeic_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [eeic_pkg::REG_WIDTH-1:0]        cfg_data,
    output eeic_pkg::cfg_t                        cfg
);

    eeic_pkg::cfg_t cfg_reg;
    eeic_pkg::cfg_t cfg_next;

    // Register decode; indexes past the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                eeic_pkg::REG_RISING_ENABLE:  cfg_next.rising_enable  = cfg_data;
                eeic_pkg::REG_FALLING_ENABLE: cfg_next.falling_enable = cfg_data;
                eeic_pkg::REG_IRQ_UNMASK:     cfg_next.irq_unmask     = cfg_data;
                eeic_pkg::REG_ROUTE_0_3:      cfg_next.route[0]       = cfg_data;
                eeic_pkg::REG_ROUTE_4_7:      cfg_next.route[1]       = cfg_data;
                eeic_pkg::REG_ROUTE_8_11:     cfg_next.route[2]       = cfg_data;
                eeic_pkg::REG_ROUTE_12_15:    cfg_next.route[3]       = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/eeic_route.sv
`timescale 1ns / 1ps

module eeic_route
(
    input  eeic_pkg::cfg_t                                                 cfg,
    input  logic [eeic_pkg::PORT_COUNT-1:0][eeic_pkg::PORT_WIDTH-1:0]      ports,
    output eeic_pkg::line_vec_t                                            levels
);

    // Per-line port select; unused codes read low
    always_comb
    begin
        logic [eeic_pkg::CODE_WIDTH-1:0] code;
        levels = '0;
        for (int i = 0; i < eeic_pkg::LINE_COUNT; i++)
        begin
            code = cfg.route[i / eeic_pkg::LINES_PER_ROUTE]
                   [(i % eeic_pkg::LINES_PER_ROUTE) * eeic_pkg::NIBBLE_WIDTH
                    +: eeic_pkg::CODE_WIDTH];
            if (32'(code) < eeic_pkg::PORT_COUNT)
            begin
                levels[i] = ports[code][i];
            end
        end
    end

endmodule

// File: design/eeic_edge.sv
`timescale 1ns / 1ps

module eeic_edge
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  eeic_pkg::item_t                    item,
    input  eeic_pkg::line_vec_t                now_levels,
    input  eeic_pkg::cfg_t                     cfg,
    output eeic_pkg::line_vec_t                pending_next,
    output eeic_pkg::line_vec_t                previous_next,
    output logic [eeic_pkg::IRQ_WIDTH-1:0]     irq_next
);

    eeic_pkg::line_vec_t previous_reg;
    eeic_pkg::line_vec_t pending_reg;
    eeic_pkg::line_vec_t active;

    // Edge detection and write-one-to-clear
    always_comb
    begin
        pending_next  = pending_reg;
        previous_next = previous_reg;
        unique case (item.mode)
            eeic_pkg::MODE_SAMPLE:
            begin
                pending_next  = pending_reg
                              | (now_levels & ~previous_reg & cfg.rising_enable)
                              | (~now_levels & previous_reg & cfg.falling_enable);
                previous_next = now_levels;
            end
            eeic_pkg::MODE_CLEAR:
            begin
                pending_next = pending_reg & ~item.clear_bits;
            end
            default:
            begin
                pending_next = pending_reg;
            end
        endcase
    end

    // Request grouping per vector
    assign active   = pending_next & cfg.irq_unmask;
    assign irq_next = {|active[15:10], |active[9:5], active[4:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_reg <= '0;
            pending_reg  <= '0;
        end
        else if (advance)
        begin
            previous_reg <= previous_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

// File: design/external_edge_interrupt_controller.sv
`timescale 1ns / 1ps

// Sixteen-line edge interrupt controller. Each transaction on the input
// channel samples routed pin levels, clears pending bits or just reads
// status, and returns one result transaction with the pending bits, grouped
// interrupt requests and stored levels. The block takes one transaction per
// clock unless the output is stalled by out_ready; a transaction is
// registered on entry and passes through the input register and the result
// register around the single edge/pending update stage. Configuration
// writes take effect on the next clock and should be made while idle.
module external_edge_interrupt_controller
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [eeic_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [eeic_pkg::REG_WIDTH-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [eeic_pkg::MODE_WIDTH-1:0]       mode,
    input  logic [eeic_pkg::LINE_COUNT-1:0]       clear_bits,
    input  logic [eeic_pkg::PORT_WIDTH-1:0]       port_a_levels,
    input  logic [eeic_pkg::PORT_WIDTH-1:0]       port_b_levels,
    input  logic [eeic_pkg::PORT_WIDTH-1:0]       port_c_levels,
    input  logic [eeic_pkg::PORT_WIDTH-1:0]       port_d_levels,
    input  logic [eeic_pkg::PORT_E_WIDTH-1:0]     port_e_levels,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [eeic_pkg::LINE_COUNT-1:0]       pending_bits,
    output logic [eeic_pkg::IRQ_WIDTH-1:0]        irq_requests,
    output logic [eeic_pkg::LINE_COUNT-1:0]       routed_levels
);

    eeic_pkg::cfg_t                   cfg;
    eeic_pkg::item_t                  item_reg;
    eeic_pkg::item_t                  item_next;
    logic                             item_valid_reg;
    logic                             out_valid_reg;
    logic                             advance;
    eeic_pkg::line_vec_t              now_levels;
    eeic_pkg::line_vec_t              pending_next;
    eeic_pkg::line_vec_t              previous_next;
    logic [eeic_pkg::IRQ_WIDTH-1:0]   irq_next;
    eeic_pkg::line_vec_t              pending_reg;
    eeic_pkg::line_vec_t              levels_reg;
    logic [eeic_pkg::IRQ_WIDTH-1:0]   irq_reg;

    eeic_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline control: stage moves when the result slot is free
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    // Input register
    always_comb
    begin
        item_next.mode       = mode;
        item_next.clear_bits = clear_bits;
        item_next.ports[0]   = port_a_levels;
        item_next.ports[1]   = port_b_levels;
        item_next.ports[2]   = port_c_levels;
        item_next.ports[3]   = port_d_levels;
        item_next.ports[4]   = eeic_pkg::PORT_WIDTH'(port_e_levels);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    eeic_route u_route
    (
        .cfg    (cfg),
        .ports  (item_reg.ports),
        .levels (now_levels)
    );

    eeic_edge u_edge
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .item          (item_reg),
        .now_levels    (now_levels),
        .cfg           (cfg),
        .pending_next  (pending_next),
        .previous_next (previous_next),
        .irq_next      (irq_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pending_reg <= pending_next;
            levels_reg  <= previous_next;
            irq_reg     <= irq_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pending_bits  = pending_reg;
    assign irq_requests  = irq_reg;
    assign routed_levels = levels_reg;

endmodule

// File: design/eeic_checker.sv
`timescale 1ns / 1ps

module eeic_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic [eeic_pkg::LINE_COUNT-1:0]       pending_bits,
    input  logic [eeic_pkg::IRQ_WIDTH-1:0]        irq_requests
);

    // A stalled result transaction holds its value
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pending_bits)
                                    && $stable(irq_requests))
        else $error("result changed while stalled");

    // Direct requests need their pending bit
    a_direct_irq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (irq_requests[4:0] & ~pending_bits[4:0]) == 5'd0)
        else $error("direct request without pending bit");

    // Grouped request for lines 5 to 9
    a_group_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && irq_requests[5] |-> |pending_bits[9:5])
        else $error("group request 5-9 without pending bit");

    // Grouped request for lines 10 to 15
    a_group_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && irq_requests[6] |-> |pending_bits[15:10])
        else $error("group request 10-15 without pending bit");

endmodule

bind external_edge_interrupt_controller eeic_checker u_eeic_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pending_bits (pending_bits),
    .irq_requests (irq_requests)
);
